[hdl/rsf_pkg.sv]
// ----------------------------------------------------------------------------
// rsf_pkg
// Shared types for the rectangle subtract block: the input and output words,
// the words that pass between pipeline stages, and the fragment slot codes.
// ----------------------------------------------------------------------------
package rsf_pkg;

  // Number of fragment slots one input word can produce
  localparam int NumFrags = 4;
  localparam int FragIdxW = $clog2(NumFrags);

  // Fragment slots, in emit order
  localparam logic [FragIdxW-1:0] SlotTop    = 2'd0;
  localparam logic [FragIdxW-1:0] SlotBottom = 2'd1;
  localparam logic [FragIdxW-1:0] SlotLeft   = 2'd2;
  localparam logic [FragIdxW-1:0] SlotRight  = 2'd3;

  typedef logic signed [15:0] coord_t;

  typedef struct packed {
    coord_t src_x;
    coord_t src_y;
    coord_t src_w;
    coord_t src_h;
    coord_t cov_x;
    coord_t cov_y;
    coord_t cov_w;
    coord_t cov_h;
  } in_word_t;

  typedef struct packed {
    coord_t frag_x;
    coord_t frag_y;
    coord_t frag_w;
    coord_t frag_h;
    logic   frag_last;
  } out_word_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  // After edge stage: inclusive right/bottom edges and emptiness flags
  typedef struct packed {
    rect_t  src;
    coord_t cov_x;
    coord_t cov_y;
    coord_t src_r;
    coord_t src_b;
    coord_t cov_r;
    coord_t cov_b;
    logic   src_empty;
    logic   cov_empty;
  } edge_word_t;

  // After overlap stage: overlap corner and inclusive far edges
  typedef struct packed {
    rect_t  src;
    coord_t src_r;
    coord_t src_b;
    coord_t ovl_x;
    coord_t ovl_y;
    coord_t ovl_r;
    coord_t ovl_b;
    logic   src_empty;
    logic   whole;
  } ovl_word_t;

  // After fragment stage: all candidate fragments and which ones exist
  typedef struct packed {
    rect_t [NumFrags-1:0] frag;
    logic  [NumFrags-1:0] mask;
  } frag_set_t;

endpackage

[hdl/rsf_edges.sv]
// ----------------------------------------------------------------------------
// rsf_edges
// Stage 1: wrapped inclusive right and bottom edges of source and cover, and
// the empty source / empty cover flags.
// ----------------------------------------------------------------------------
module rsf_edges (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsf_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output rsf_pkg::edge_word_t out_word
);

  rsf_pkg::edge_word_t word_next;

  // Form edges and flags
  always_comb begin
    word_next.src.x     = in_word.src_x;
    word_next.src.y     = in_word.src_y;
    word_next.src.w     = in_word.src_w;
    word_next.src.h     = in_word.src_h;
    word_next.cov_x     = in_word.cov_x;
    word_next.cov_y     = in_word.cov_y;
    word_next.src_r     = rsf_pkg::coord_t'(in_word.src_x + in_word.src_w - 16'sd1);
    word_next.src_b     = rsf_pkg::coord_t'(in_word.src_y + in_word.src_h - 16'sd1);
    word_next.cov_r     = rsf_pkg::coord_t'(in_word.cov_x + in_word.cov_w - 16'sd1);
    word_next.cov_b     = rsf_pkg::coord_t'(in_word.cov_y + in_word.cov_h - 16'sd1);
    word_next.src_empty = (in_word.src_w <= 16'sd0) || (in_word.src_h <= 16'sd0);
    word_next.cov_empty = (in_word.cov_w <= 16'sd0) || (in_word.cov_h <= 16'sd0);
  end

  assign in_ready = !out_valid || out_ready;

  // Advance the stage when the next one can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

[hdl/rsf_overlap.sv]
// ----------------------------------------------------------------------------
// rsf_overlap
// Stage 2: disjoint test, overlap corner (max of left/top edges) and overlap
// far edges (min of right/bottom edges).
// ----------------------------------------------------------------------------
module rsf_overlap (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsf_pkg::edge_word_t in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output rsf_pkg::ovl_word_t  out_word
);

  rsf_pkg::ovl_word_t word_next;
  logic               disjoint;

  // Find overlap box; the far edge of the overlap is the nearer far edge
  always_comb begin
    disjoint = (in_word.src_r < in_word.cov_x) || (in_word.cov_r < in_word.src.x) ||
               (in_word.src_b < in_word.cov_y) || (in_word.cov_b < in_word.src.y);
    word_next.src       = in_word.src;
    word_next.src_r     = in_word.src_r;
    word_next.src_b     = in_word.src_b;
    word_next.ovl_x     = (in_word.src.x > in_word.cov_x) ? in_word.src.x : in_word.cov_x;
    word_next.ovl_y     = (in_word.src.y > in_word.cov_y) ? in_word.src.y : in_word.cov_y;
    word_next.ovl_r     = (in_word.src_r < in_word.cov_r) ? in_word.src_r : in_word.cov_r;
    word_next.ovl_b     = (in_word.src_b < in_word.cov_b) ? in_word.src_b : in_word.cov_b;
    word_next.src_empty = in_word.src_empty;
    word_next.whole     = in_word.cov_empty || disjoint;
  end

  assign in_ready = !out_valid || out_ready;

  // Advance the stage when the next one can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

[hdl/rsf_frags.sv]
// ----------------------------------------------------------------------------
// rsf_frags
// Stage 3: build the top, bottom, left and right fragments and the mask of
// those that are non-empty. An untouched source becomes a single fragment;
// an empty source gives an empty mask.
// ----------------------------------------------------------------------------
module rsf_frags (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rsf_pkg::ovl_word_t in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output rsf_pkg::frag_set_t out_word
);

  rsf_pkg::frag_set_t set_next;
  rsf_pkg::coord_t    ovl_h;

  // Build fragments
  always_comb begin
    ovl_h = rsf_pkg::coord_t'(in_word.ovl_b - in_word.ovl_y + 16'sd1);

    set_next.frag[rsf_pkg::SlotTop].x = in_word.src.x;
    set_next.frag[rsf_pkg::SlotTop].y = in_word.src.y;
    set_next.frag[rsf_pkg::SlotTop].w = in_word.src.w;
    set_next.frag[rsf_pkg::SlotTop].h = rsf_pkg::coord_t'(in_word.ovl_y - in_word.src.y);

    set_next.frag[rsf_pkg::SlotBottom].x = in_word.src.x;
    set_next.frag[rsf_pkg::SlotBottom].y = rsf_pkg::coord_t'(in_word.ovl_b + 16'sd1);
    set_next.frag[rsf_pkg::SlotBottom].w = in_word.src.w;
    set_next.frag[rsf_pkg::SlotBottom].h =
      rsf_pkg::coord_t'(in_word.src_b - in_word.ovl_b);

    set_next.frag[rsf_pkg::SlotLeft].x = in_word.src.x;
    set_next.frag[rsf_pkg::SlotLeft].y = in_word.ovl_y;
    set_next.frag[rsf_pkg::SlotLeft].w = rsf_pkg::coord_t'(in_word.ovl_x - in_word.src.x);
    set_next.frag[rsf_pkg::SlotLeft].h = ovl_h;

    set_next.frag[rsf_pkg::SlotRight].x = rsf_pkg::coord_t'(in_word.ovl_r + 16'sd1);
    set_next.frag[rsf_pkg::SlotRight].y = in_word.ovl_y;
    set_next.frag[rsf_pkg::SlotRight].w = rsf_pkg::coord_t'(in_word.src_r - in_word.ovl_r);
    set_next.frag[rsf_pkg::SlotRight].h = ovl_h;

    set_next.mask[rsf_pkg::SlotTop]    = in_word.src.y < in_word.ovl_y;
    set_next.mask[rsf_pkg::SlotBottom] = in_word.ovl_b < in_word.src_b;
    set_next.mask[rsf_pkg::SlotLeft]   = in_word.src.x < in_word.ovl_x;
    set_next.mask[rsf_pkg::SlotRight]  = in_word.ovl_r < in_word.src_r;

    // Untouched source: pass it on as the only fragment
    if (in_word.whole) begin
      set_next.frag[rsf_pkg::SlotTop] = in_word.src;
      set_next.mask = '0;
      set_next.mask[rsf_pkg::SlotTop] = 1'b1;
    end

    // Empty source: drop everything
    if (in_word.src_empty) begin
      set_next.mask = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  // Advance the stage when the emitter can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= set_next;
    end
  end

endmodule

[hdl/rsf_emit.sv]
// ----------------------------------------------------------------------------
// rsf_emit
// Output stage: holds one fragment set and sends its fragments in slot order,
// one word per cycle while out_stall is low, marking the final one. Loads the
// next set in the cycle the final word leaves.
// ----------------------------------------------------------------------------
module rsf_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rsf_pkg::frag_set_t in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output rsf_pkg::out_word_t out_word
);

  rsf_pkg::rect_t [rsf_pkg::NumFrags-1:0] frag;
  logic [rsf_pkg::NumFrags-1:0]           mask;
  logic [rsf_pkg::NumFrags-1:0]           pick;
  logic [rsf_pkg::NumFrags-1:0]           mask_next;
  logic [rsf_pkg::FragIdxW-1:0]           sel;
  logic                                   last;
  logic                                   take;

  // Pick the lowest pending slot
  always_comb begin
    sel = '0;
    for (int i = rsf_pkg::NumFrags - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = rsf_pkg::FragIdxW'(i);
      end
    end
  end

  assign pick      = mask & (~mask + 1'b1);
  assign last      = (mask & ~pick) == '0;
  assign out_valid = |mask;
  assign take      = out_valid && !out_stall;
  assign in_ready  = !out_valid || (take && last);

  assign out_word.frag_x    = frag[sel].x;
  assign out_word.frag_y    = frag[sel].y;
  assign out_word.frag_w    = frag[sel].w;
  assign out_word.frag_h    = frag[sel].h;
  assign out_word.frag_last = last;

  // Drop the sent slot, or load a new set once the current one is done
  always_comb begin
    mask_next = mask;
    if (take) begin
      mask_next = mask & ~pick;
    end
    if (in_ready && in_valid) begin
      mask_next = in_word.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      frag <= in_word.frag;
    end
  end

endmodule

[hdl/rectangle_subtract_fragments.sv]
// ----------------------------------------------------------------------------
// rectangle_subtract_fragments
// Subtracts a cover rectangle from a source rectangle and sends the uncovered
// parts as up to four fragment words: top band, bottom band, left sliver,
// right sliver, with the final one marked.
//
//   channel | dir | handshake          | word
//   --------+-----+--------------------+----------------------------
//   in      | in  | in_valid/in_stall  | rsf_pkg::in_word_t  (src, cov)
//   out     | out | out_valid/out_stall| rsf_pkg::out_word_t (fragment)
//
// Four register stages: edges, overlap, fragment build, emitter. A word is
// registered in the edge, overlap and fragment stages before its first
// fragment is on out. The emitter sends one fragment per cycle while out
// is not stalled; a word has 1 to 4 fragments, or none, and the stages ahead
// keep taking words meanwhile. Reset clears all valid bits and the emitter
// mask. A stall on out backs up stage by stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rectangle_subtract_fragments (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rsf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rsf_pkg::out_word_t out_data
);

  logic                edge_valid;
  logic                edge_ready;
  logic                ovl_valid;
  logic                ovl_ready;
  logic                frag_valid;
  logic                frag_ready;
  logic                in_ready;
  rsf_pkg::edge_word_t edge_word;
  rsf_pkg::ovl_word_t  ovl_word;
  rsf_pkg::frag_set_t  frag_set;

  assign in_stall = !in_ready;

  rsf_edges u_edges (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_data),
    .out_valid (edge_valid),
    .out_ready (edge_ready),
    .out_word  (edge_word)
  );

  rsf_overlap u_overlap (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (edge_valid),
    .in_ready  (edge_ready),
    .in_word   (edge_word),
    .out_valid (ovl_valid),
    .out_ready (ovl_ready),
    .out_word  (ovl_word)
  );

  rsf_frags u_frags (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ovl_valid),
    .in_ready  (ovl_ready),
    .in_word   (ovl_word),
    .out_valid (frag_valid),
    .out_ready (frag_ready),
    .out_word  (frag_set)
  );

  rsf_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frag_valid),
    .in_ready  (frag_ready),
    .in_word   (frag_set),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_data)
  );

endmodule

[tb/sv/rectangle_subtract_fragments_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_subtract_fragments_chk
// Watches both channels of the rectangle subtract block. For every accepted
// input word it cuts the source by the cover and queues the fragment words
// that must follow. Every accepted output word is compared field by field
// against the oldest queued fragment. Counts go back to the testbench top.
// ----------------------------------------------------------------------------
module rectangle_subtract_fragments_chk (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rsf_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rsf_pkg::out_word_t out_data,
  output int                 errors,
  output int                 waiting,
  output int                 checked,
  output int                 closed
);

  rsf_pkg::out_word_t pending_frags [$];
  int                 n_err   = 0;
  int                 n_chk   = 0;
  int                 n_close = 0;

  // Build one fragment word, not yet marked as the last one
  function automatic rsf_pkg::out_word_t piece(rsf_pkg::coord_t x, rsf_pkg::coord_t y,
                                               rsf_pkg::coord_t w, rsf_pkg::coord_t h);
    rsf_pkg::out_word_t p;
    p.frag_x    = x;
    p.frag_y    = y;
    p.frag_w    = w;
    p.frag_h    = h;
    p.frag_last = 1'b0;
    return p;
  endfunction

  // Subtract the cover from the source and queue the surviving fragments
  function automatic void cut_fragments(rsf_pkg::in_word_t w);
    rsf_pkg::coord_t    s_r, s_b, c_r, c_b;
    rsf_pkg::coord_t    ox, oy, ow, oh, o_r, o_b, near_r, near_b;
    rsf_pkg::out_word_t parts [$];
    if (w.src_w <= 0 || w.src_h <= 0) return;
    // inclusive far edges, wrapped to 16 bits
    s_r = w.src_x + w.src_w - 16'sd1;
    s_b = w.src_y + w.src_h - 16'sd1;
    c_r = w.cov_x + w.cov_w - 16'sd1;
    c_b = w.cov_y + w.cov_h - 16'sd1;
    if (w.cov_w <= 0 || w.cov_h <= 0 ||
        s_r < w.cov_x || c_r < w.src_x || s_b < w.cov_y || c_b < w.src_y) begin
      // no cover or no overlap: pass the source through whole
      parts.push_back(piece(w.src_x, w.src_y, w.src_w, w.src_h));
    end else begin
      ox     = (w.src_x > w.cov_x) ? w.src_x : w.cov_x;
      oy     = (w.src_y > w.cov_y) ? w.src_y : w.cov_y;
      near_r = (s_r < c_r) ? s_r : c_r;
      near_b = (s_b < c_b) ? s_b : c_b;
      ow     = near_r - ox + 16'sd1;
      oh     = near_b - oy + 16'sd1;
      o_r    = ox + ow - 16'sd1;
      o_b    = oy + oh - 16'sd1;
      // top band, bottom band, left sliver, right sliver
      if (w.src_y < oy)
        parts.push_back(piece(w.src_x, w.src_y, w.src_w, oy - w.src_y));
      if (o_b < s_b)
        parts.push_back(piece(w.src_x, o_b + 16'sd1, w.src_w, s_b - o_b));
      if (w.src_x < ox)
        parts.push_back(piece(w.src_x, oy, ox - w.src_x, oh));
      if (o_r < s_r)
        parts.push_back(piece(o_r + 16'sd1, oy, s_r - o_r, oh));
    end
    if (parts.size() > 0) parts[parts.size()-1].frag_last = 1'b1;
    foreach (parts[i]) pending_frags.push_back(parts[i]);
  endfunction

  // Compare one field and report it when it differs
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
      n_err++;
    end
  endfunction

  // Check outputs first, then queue the fragments of a newly accepted word
  always @(posedge clk) begin
    rsf_pkg::out_word_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_frags.size() == 0) begin
          $display("%0t: unexpected fragment word: actual x=%0d y=%0d w=%0d h=%0d last=%0b",
                   $time, out_data.frag_x, out_data.frag_y, out_data.frag_w,
                   out_data.frag_h, out_data.frag_last);
          n_err++;
        end else begin
          want = pending_frags.pop_front();
          check_field("frag_x", want.frag_x, out_data.frag_x);
          check_field("frag_y", want.frag_y, out_data.frag_y);
          check_field("frag_w", want.frag_w, out_data.frag_w);
          check_field("frag_h", want.frag_h, out_data.frag_h);
          check_field("frag_last", want.frag_last, out_data.frag_last);
          n_chk++;
          if (want.frag_last) n_close++;
        end
      end
      if (in_valid && !in_stall) cut_fragments(in_data);
    end
    errors  <= n_err;
    waiting <= pending_frags.size();
    checked <= n_chk;
    closed  <= n_close;
  end

endmodule

[tb/sv/rectangle_subtract_fragments_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_subtract_fragments_tb
// Drives source/cover rectangle pairs into the block: a directed set of
// corner cases, then shaped random words in bursts, against a receiver that
// stalls on changing patterns and once for a long stretch. A checker beside
// the block predicts and compares every fragment word.
// ----------------------------------------------------------------------------
module rectangle_subtract_fragments_tb;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  rsf_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall;
  rsf_pkg::out_word_t out_data;
  logic               hold_req;

  int errors;
  int waiting;
  int checked;
  int closed;
  int words_sent = 0;

  rectangle_subtract_fragments DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  rectangle_subtract_fragments_chk frag_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .errors    (errors),
    .waiting   (waiting),
    .checked   (checked),
    .closed    (closed)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  // Receiver: stall patterns that change now and then, one long hold-off
  initial begin
    int hold_left;
    int run_left;
    int mode;
    int phase;
    logic hold_done;
    hold_left = 0;
    run_left  = 0;
    mode      = 0;
    phase     = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 3);
          run_left = $urandom_range(20, 150);
        end
        run_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((phase % 5) < 2);
        endcase
      end
    end
  end

  // Pack one source/cover pair
  function automatic rsf_pkg::in_word_t rects(int sx, int sy, int sw, int sh,
                                              int cx, int cy, int cw, int ch);
    rsf_pkg::in_word_t w;
    w.src_x = rsf_pkg::coord_t'(sx);
    w.src_y = rsf_pkg::coord_t'(sy);
    w.src_w = rsf_pkg::coord_t'(sw);
    w.src_h = rsf_pkg::coord_t'(sh);
    w.cov_x = rsf_pkg::coord_t'(cx);
    w.cov_y = rsf_pkg::coord_t'(cy);
    w.cov_w = rsf_pkg::coord_t'(cw);
    w.cov_h = rsf_pkg::coord_t'(ch);
    return w;
  endfunction

  // Shaped random word: mostly overlapping pairs of small size
  function automatic rsf_pkg::in_word_t make_word();
    rsf_pkg::in_word_t w;
    int kind;
    int sw;
    int sh;
    int pad;
    kind = $urandom_range(0, 19);
    w = rsf_pkg::in_word_t'({$urandom, $urandom, $urandom, $urandom});
    if (kind >= 2) begin
      sw = (kind == 19) ? $urandom_range(1, 32767) : $urandom_range(1, 48);
      sh = (kind == 19) ? $urandom_range(1, 32767) : $urandom_range(1, 48);
      // push the source against the top of the coordinate range
      if (kind == 3) begin
        w.src_x = rsf_pkg::coord_t'(32767 - int'($urandom_range(0, 40)));
        w.src_y = rsf_pkg::coord_t'(32767 - int'($urandom_range(0, 40)));
      end
      w.src_w = rsf_pkg::coord_t'(sw);
      w.src_h = rsf_pkg::coord_t'(sh);
      w.cov_x = w.src_x + rsf_pkg::coord_t'($urandom_range(0, sw + 24) - 12);
      w.cov_y = w.src_y + rsf_pkg::coord_t'($urandom_range(0, sh + 24) - 12);
      w.cov_w = rsf_pkg::coord_t'($urandom_range(1, sw + 16));
      w.cov_h = rsf_pkg::coord_t'($urandom_range(1, sh + 16));
      case (kind)
        4: w.cov_w = rsf_pkg::coord_t'(-int'($urandom_range(0, 32768)));
        5: w.src_h = rsf_pkg::coord_t'(-int'($urandom_range(0, 100)));
        6: begin
          // cover encloses the source
          pad = $urandom_range(0, 5);
          w.cov_x = w.src_x - rsf_pkg::coord_t'(pad);
          w.cov_y = w.src_y - rsf_pkg::coord_t'(pad);
          w.cov_w = rsf_pkg::coord_t'(sw + 2 * pad + int'($urandom_range(0, 3)));
          w.cov_h = rsf_pkg::coord_t'(sh + 2 * pad + int'($urandom_range(0, 3)));
        end
        default: ;
      endcase
    end
    return w;
  endfunction

  // Offer one word and hold it until accepted
  task automatic offer(rsf_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Drop valid for a number of cycles
  task automatic idle_for(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop valid and wait until every queued fragment has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // Stimulus and verdict
  initial begin
    int burst_left;
    int directed;
    burst_left = 0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    hold_req <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corner cases
    offer(rects(0, 0, 0, 10, 0, 0, 5, 5));                  // empty source, zero width
    offer(rects(0, 0, 10, -32768, 0, 0, 5, 5));             // empty source, negative height
    offer(rects(10, 20, 30, 40, 15, 25, 0, 5));             // no cover, zero width
    offer(rects(10, 20, 30, 40, 15, 25, 5, -1));            // no cover, negative height
    offer(rects(10, 20, 30, 40, 40, 20, 5, 5));             // cover just right of source
    offer(rects(10, 20, 30, 40, 10, 10, 30, 10));           // cover just above source
    offer(rects(10, 20, 30, 40, 0, 0, 100, 100));           // cover encloses source
    offer(rects(10, 20, 30, 40, 10, 20, 30, 40));           // exact cover
    offer(rects(10, 20, 30, 40, 15, 25, 10, 10));           // hole: all four pieces
    offer(rects(10, 20, 30, 40, 0, 0, 20, 30));             // top-left corner cut
    offer(rects(10, 20, 30, 40, 30, 50, 50, 50));           // bottom-right corner cut
    offer(rects(10, 20, 30, 40, 0, 30, 100, 5));            // horizontal stripe
    offer(rects(10, 20, 30, 40, 20, 0, 5, 100));            // vertical stripe
    offer(rects(32767, 32767, 32767, 32767, 0, 0, 5, 5));   // far edges wrap
    offer(rects(-32768, -32768, 32767, 32767, -100, -100, 50, 50));
    offer(rects(0, 0, 100, 100, 32000, 50, 2000, 10));      // cover edge wraps
    offer(rects(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    offer(rects(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    offer(rects(-1, -1, -1, -1, -1, -1, -1, -1));
    offer(rects(0, 0, 0, 0, 0, 0, 0, 0));
    offer(rects(-1, -1, 1, 1, -1, -1, 1, 1));               // one-pixel exact cover
    offer(rects(5, 5, 1, 1, 0, 0, 3, 3));                   // one-pixel source, disjoint
    directed = words_sent;
    drain();

    // Random words in bursts, with a long receiver hold-off and drain pauses
    for (int i = 0; i < 340; i++) begin
      if (i == 100) begin
        // keep offering while the receiver holds off, so the block backs up
        hold_req <= 1'b1;
        repeat (40) offer(make_word());
      end
      if (i == 150 || i == 300) drain();
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 10);
        idle_for($urandom_range(1, 8));
      end
      burst_left--;
      offer(make_word());
    end

    // Let everything drain, then allow for stray words
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d input words (%0d directed, the rest shaped random).",
             words_sent, directed);
    $display("Compared %0d fragment words closing %0d input words.", checked, closed);
    if (errors == 0 && waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
